@@ rtl/ode_pkg.sv @@
// ----------------------------------------------------------------------------
// ode_pkg
// Shared types and constants of the offset difference emboss filter.
// ----------------------------------------------------------------------------
package ode_pkg;

  localparam int PIX_W   = 8;
  localparam int LEVEL_W = 8;
  localparam int WORD_W  = 32;
  localparam int ROW_W   = 10;
  localparam int REG_IDX_W = 3;

  localparam logic [ROW_W-1:0] ROW_MAX = 10'd1023;

  // Register map, one 32-bit word per register
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TRUECOLOR_MODE = 3'd0,
    REG_X_OFFSET       = 3'd1,
    REG_Y_OFFSET       = 3'd2,
    REG_LINE_WIDTH     = 3'd3,
    REG_RED_FORMAT     = 3'd4,
    REG_GREEN_FORMAT   = 3'd5,
    REG_BLUE_FORMAT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        truecolor_mode;
    logic [3:0]  x_offset;
    logic [3:0]  y_offset;
    logic [10:0] line_width;
    logic [9:0]  red_format;
    logic [9:0]  green_format;
    logic [9:0]  blue_format;
  } cfg_t;

  localparam logic        RST_TRUECOLOR_MODE = 1'b1;
  localparam logic [3:0]  RST_X_OFFSET       = 4'd1;
  localparam logic [3:0]  RST_Y_OFFSET       = 4'd1;
  localparam logic [10:0] RST_LINE_WIDTH     = 11'd1024;
  localparam logic [9:0]  RST_RED_FORMAT     = 10'd16;
  localparam logic [9:0]  RST_GREEN_FORMAT   = 10'd8;
  localparam logic [9:0]  RST_BLUE_FORMAT    = 10'd0;

endpackage

@@ rtl/ode_cfg.sv @@
// ----------------------------------------------------------------------------
// ode_cfg
// APB register file holding the filter configuration.
// ----------------------------------------------------------------------------
module ode_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ode_pkg::cfg_t cfg
);
  import ode_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TRUECOLOR_MODE: cfg_nxt.truecolor_mode = pwdata[0];
        REG_X_OFFSET:       cfg_nxt.x_offset       = pwdata[3:0];
        REG_Y_OFFSET:       cfg_nxt.y_offset       = pwdata[3:0];
        REG_LINE_WIDTH:     cfg_nxt.line_width     = pwdata[10:0];
        REG_RED_FORMAT:     cfg_nxt.red_format     = pwdata[9:0];
        REG_GREEN_FORMAT:   cfg_nxt.green_format   = pwdata[9:0];
        REG_BLUE_FORMAT:    cfg_nxt.blue_format    = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TRUECOLOR_MODE: prdata = {31'd0, cfg_r.truecolor_mode};
      REG_X_OFFSET:       prdata = {28'd0, cfg_r.x_offset};
      REG_Y_OFFSET:       prdata = {28'd0, cfg_r.y_offset};
      REG_LINE_WIDTH:     prdata = {21'd0, cfg_r.line_width};
      REG_RED_FORMAT:     prdata = {22'd0, cfg_r.red_format};
      REG_GREEN_FORMAT:   prdata = {22'd0, cfg_r.green_format};
      REG_BLUE_FORMAT:    prdata = {22'd0, cfg_r.blue_format};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.truecolor_mode <= RST_TRUECOLOR_MODE;
      cfg_r.x_offset       <= RST_X_OFFSET;
      cfg_r.y_offset       <= RST_Y_OFFSET;
      cfg_r.line_width     <= RST_LINE_WIDTH;
      cfg_r.red_format     <= RST_RED_FORMAT;
      cfg_r.green_format   <= RST_GREEN_FORMAT;
      cfg_r.blue_format    <= RST_BLUE_FORMAT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/ode_addr_gen.sv @@
// ----------------------------------------------------------------------------
// ode_addr_gen
// Raster position tracking, delay line write pointer and compare address.
// ----------------------------------------------------------------------------
module ode_addr_gen #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int MAX_OFFSET     = 15,
  parameter int DELAY_DEPTH    = 16384,
  parameter int AW             = $clog2(DELAY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          frame_start,
  input  ode_pkg::cfg_t cfg,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr,
  output logic          hit
);
  import ode_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int LW_W  = (COL_W + 1 > 11) ? COL_W + 1 : 11;
  localparam int OW    = ($clog2(MAX_OFFSET + 1) > 4) ? $clog2(MAX_OFFSET + 1) : 4;
  localparam int DLY_W = OW + LW_W + 1;
  localparam int SUB_W = ((AW > DLY_W) ? AW : DLY_W) + 1;

  localparam logic [LW_W-1:0]  W_MIN   = LW_W'(2);
  localparam logic [LW_W-1:0]  W_MAX   = LW_W'(MAX_LINE_WIDTH);
  localparam logic [OW-1:0]    OFS_MAX = OW'(MAX_OFFSET);
  localparam logic [OW-1:0]    OFS_MIN = OW'(1);
  localparam logic [AW-1:0]    WP_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [SUB_W-1:0] DEPTH_S = SUB_W'(DELAY_DEPTH);

  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic [AW-1:0]    wp_r, wp_nxt;

  logic [LW_W-1:0]  lw_ext, w, col_inc;
  logic [OW-1:0]    x_ext, y_ext, xd, yd;
  logic [DLY_W-1:0] delay;
  logic [SUB_W-1:0] diff, raddr_s;
  logic             wrap;

  always_comb begin
    lw_ext = LW_W'(cfg.line_width);
    x_ext  = OW'(cfg.x_offset);
    y_ext  = OW'(cfg.y_offset);

    if (lw_ext < W_MIN)      w = W_MIN;
    else if (lw_ext > W_MAX) w = W_MAX;
    else                     w = lw_ext;

    if (x_ext < OFS_MIN)        xd = OFS_MIN;
    else if (x_ext > OFS_MAX)   xd = OFS_MAX;
    else                        xd = x_ext;

    if (y_ext < OFS_MIN)        yd = OFS_MIN;
    else if (y_ext > OFS_MAX)   yd = OFS_MAX;
    else                        yd = y_ext;

    col_cur = frame_start ? '0 : col_r;
    row_cur = frame_start ? '0 : row_r;

    hit = (LW_W'(col_cur) >= LW_W'(xd)) && (row_cur >= ROW_W'(yd));

    // Compared pixel lies yd lines plus xd pixels back in the stream
    delay   = DLY_W'(yd) * DLY_W'(w) + DLY_W'(xd);
    diff    = SUB_W'(wp_r) - SUB_W'(delay);
    raddr_s = diff[SUB_W-1] ? diff + DEPTH_S : diff;
    rd_addr = raddr_s[AW-1:0];

    col_inc = LW_W'(col_cur) + LW_W'(1);
    wrap    = (col_inc >= w);
    col_nxt = wrap ? '0 : col_inc[COL_W-1:0];
    row_nxt = (wrap && (row_cur != ROW_MAX)) ? row_cur + ROW_W'(1) : row_cur;
    wp_nxt  = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
  end

  assign wr_addr = wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      wp_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      wp_r  <= wp_nxt;
    end
  end

endmodule

@@ rtl/ode_delay_ram.sv @@
// ----------------------------------------------------------------------------
// ode_delay_ram
// Pixel delay line: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ode_delay_ram #(
  parameter int DELAY_DEPTH = 16384,
  parameter int AW          = $clog2(DELAY_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ode_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ode_pkg::PIX_W-1:0] rd_data
);
  import ode_pkg::*;

  logic [PIX_W-1:0] mem [DELAY_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ode_relief.sv @@
// ----------------------------------------------------------------------------
// ode_relief
// Pixel difference to relief level, palette quantizing and truecolor packing.
// ----------------------------------------------------------------------------
module ode_relief (
  input  logic [ode_pkg::PIX_W-1:0]   new_pixel,
  input  logic [ode_pkg::PIX_W-1:0]   old_pixel,
  input  ode_pkg::cfg_t               cfg,
  output logic [ode_pkg::WORD_W-1:0]  embossed,
  output logic [ode_pkg::LEVEL_W-1:0] level
);
  import ode_pkg::*;

  localparam logic [6:0] PAL_MID = 7'd32;
  localparam logic [5:0] PAL_MAX = 6'd63;
  localparam logic [8:0] TC_MID  = 9'd128;

  function automatic logic [WORD_W-1:0] pack_channel(input logic [LEVEL_W-1:0] lvl,
                                                     input logic [9:0] fmt);
    logic [LEVEL_W-1:0] shr;
    shr = lvl >> fmt[9:5];
    return WORD_W'(shr) << fmt[4:0];
  endfunction

  logic [8:0] diff;
  logic [9:0] mag_neg;
  logic [8:0] pos_p3;
  logic [9:0] neg_p3;
  logic [6:0] q_pos, q_neg;
  logic [5:0] pal_lvl;
  logic [7:0] tc_lvl;
  logic [8:0] tc_sum;

  always_comb begin
    diff    = {1'b0, new_pixel} - {1'b0, old_pixel};
    mag_neg = 10'd512 - {1'b0, diff};
    pos_p3  = {1'b0, diff[7:0]} + 9'd3;
    neg_p3  = mag_neg + 10'd3;
    q_pos   = 7'(pos_p3 >> 2);
    q_neg   = 7'(neg_p3 >> 2);
    tc_sum  = {1'b0, diff[7:0]} + TC_MID;

    if (!diff[8]) begin
      // round up, then clamp at the top of the palette
      pal_lvl = (q_pos > 7'd31) ? PAL_MAX : 6'(q_pos + PAL_MID);
      tc_lvl  = tc_sum[8] ? 8'd255 : tc_sum[7:0];
    end else begin
      pal_lvl = (q_neg >= PAL_MID) ? 6'd0 : 6'(PAL_MID - q_neg);
      tc_lvl  = (mag_neg >= 10'(TC_MID)) ? 8'd0 : 8'(10'(TC_MID) - mag_neg);
    end

    if (cfg.truecolor_mode) begin
      level    = tc_lvl;
      embossed = pack_channel(tc_lvl, cfg.red_format)
               | pack_channel(tc_lvl, cfg.green_format)
               | pack_channel(tc_lvl, cfg.blue_format);
    end else begin
      level    = {2'd0, pal_lvl};
      embossed = WORD_W'(pal_lvl);
    end
  end

endmodule

@@ rtl/offset_difference_emboss.sv @@
// ----------------------------------------------------------------------------
// offset_difference_emboss
// Streaming emboss filter over a raster of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled; a result passes the compare
// stage and then the output register. Each pixel is written to a delay line
// RAM with one write and one read port, both used in the cycle of
// acceptance, and this RAM sets the rate of one pixel per cycle. Pixels at
// column >= x_offset and row >= y_offset (an offset of 0 acts as 1) are
// compared with the pixel that many columns left and rows up; other pixels
// give no result. The RAM is not cleared after reset: every frame must start
// with frame_start, and offsets and line width must stay fixed within a
// frame. DELAY_DEPTH must exceed MAX_OFFSET*(MAX_LINE_WIDTH+1). A result
// waiting at the output still lets one request into the compare stage; once
// that stage also holds a result, the input stalls until the output is taken.
// ----------------------------------------------------------------------------
module offset_difference_emboss #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int MAX_OFFSET     = 15,
  parameter int DELAY_DEPTH    = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_pixel,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_embossed_pixel,
  output logic [7:0]  out_relief_level,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ode_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  cfg_t              cfg;
  logic              accept, hit, s1_move;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [PIX_W-1:0]  old_pixel;
  logic [WORD_W-1:0] embossed;
  logic [LEVEL_W-1:0] level;

  logic               s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]   s1_pixel_r;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r;
  logic [LEVEL_W-1:0] out_level_r;

  ode_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ode_addr_gen #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_OFFSET     (MAX_OFFSET),
    .DELAY_DEPTH    (DELAY_DEPTH),
    .AW             (AW)
  ) u_addr_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_frame_start),
    .cfg         (cfg),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .hit         (hit)
  );

  ode_delay_ram #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .AW          (AW)
  ) u_delay_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_addr),
    .wr_data (in_source_pixel),
    .rd_en   (accept && hit),
    .rd_addr (rd_addr),
    .rd_data (old_pixel)
  );

  ode_relief u_relief (
    .new_pixel (s1_pixel_r),
    .old_pixel (old_pixel),
    .cfg       (cfg),
    .embossed  (embossed),
    .level     (level)
  );

  // Advance the compare stage when it holds a result and the output register is free or drains
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_move) s1_valid_nxt = 1'b0;
    if (accept)  s1_valid_nxt = hit;

    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (s1_move)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      s1_pixel_r <= in_source_pixel;
    end
    if (s1_move) begin
      out_word_r  <= embossed;
      out_level_r <= level;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_embossed_pixel = out_word_r;
  assign out_relief_level   = out_level_r;

endmodule

@@ rtl/ode_checker.sv @@
// ----------------------------------------------------------------------------
// ode_checker
// Port-level checks of the emboss filter, bound to the top level.
// ----------------------------------------------------------------------------
module ode_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_embossed_pixel,
  input logic [7:0]  out_relief_level
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_embossed_pixel)
                                && $stable(out_relief_level))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result comes from an earlier accepted request
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

  // An empty output never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

endmodule

bind offset_difference_emboss ode_checker u_ode_checker (.*);
